// File: rtl/core/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the pressure compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int NUM_REGS = 6;
	localparam logic [2:0] REG_AC1_AC2 = 3'd0;
	localparam logic [2:0] REG_AC3_AC4 = 3'd1;
	localparam logic [2:0] REG_AC5_AC6 = 3'd2;
	localparam logic [2:0] REG_B1_B2   = 3'd3;
	localparam logic [2:0] REG_MC_MD   = 3'd4;
	localparam logic [2:0] REG_OSS     = 3'd5;

	// one queued item between front and back
	typedef struct packed {
		logic [15:0] raw_temp;
		logic [23:0] raw_press;
	} bpc_item_t;

	typedef struct packed {
		logic [15:0] temp_deci_c;
		logic [31:0] press_pa;
		logic        div_error;
	} bpc_result_t;

	// coefficient set as seen by the datapath
	typedef struct packed {
		logic [31:0] ac1_ac2;
		logic [31:0] ac3_ac4;
		logic [31:0] ac5_ac6;
		logic [31:0] b1_b2;
		logic [31:0] mc_md;
		logic [1:0]  oss;
	} bpc_coef_t;

endpackage

// File: rtl/core/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div
// Unsigned 32/32 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpc_div import bpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q, quo_q[31]};
	assign trial   = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;

endmodule

// File: rtl/core/bpc_front.sv
// ----------------------------------------------------------------------------
// bpc_front
// Input side: accepts items and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module bpc_front import bpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  bpc_item_t in_item,
	output logic      q_valid,
	input  logic      q_pop,
	output bpc_item_t q_item
);

	bpc_item_t  mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	ap_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	ap_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count overflow");
	ap_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !in_ready) else $error("accept when full");

endmodule

// File: rtl/core/bpc_back.sv
// ----------------------------------------------------------------------------
// bpc_back
// Compensation sequencer: at most one multiply per step, shared divider.
// ----------------------------------------------------------------------------
module bpc_back import bpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bpc_coef_t   coef,
	input  logic        q_valid,
	output logic        q_pop,
	input  bpc_item_t   q_item,
	output logic        res_valid,
	input  logic        res_ready,
	output bpc_result_t res
);

	localparam logic [4:0] S_IDLE = 5'd0,  S_X1T = 5'd1,  S_DEN = 5'd2,
		S_SDIV = 5'd3, S_WDIV = 5'd4, S_B5 = 5'd5,  S_SQ = 5'd6,
		S_X1B2 = 5'd7, S_AC2 = 5'd8,  S_B3 = 5'd9,  S_AC3 = 5'd10,
		S_B1 = 5'd11,  S_B4 = 5'd12,  S_B4C = 5'd13, S_B7 = 5'd14,
		S_PDIV = 5'd15, S_PW = 5'd16, S_P1 = 5'd17, S_P2 = 5'd18,
		S_P3 = 5'd19,  S_P4 = 5'd20,  S_OUT = 5'd21;

	logic [4:0]  st_q;
	logic [31:0] x1_q, x2_q, b5_q, b6_q, sq_q, b3_q, b4_q, b7_q, p_q;
	logic [15:0] ut_q;
	logic [23:0] up_q;
	logic        neg_q, b7hi_q;
	logic [15:0] rt_q;
	logic [31:0] rp_q;
	logic        re_q;
	logic        div_start;
	logic [31:0] div_a, div_b, div_quo;
	logic        div_done;
	logic        out_full_q;
	logic        out_load;

	logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [15:0] ac4, ac5, ac6;
	assign ac1 = 32'(signed'(coef.ac1_ac2[31:16]));
	assign ac2 = 32'(signed'(coef.ac1_ac2[15:0]));
	assign ac3 = 32'(signed'(coef.ac3_ac4[31:16]));
	assign ac4 = coef.ac3_ac4[15:0];
	assign ac5 = coef.ac5_ac6[31:16];
	assign ac6 = coef.ac5_ac6[15:0];
	assign b1  = 32'(signed'(coef.b1_b2[31:16]));
	assign b2  = 32'(signed'(coef.b1_b2[15:0]));
	assign mc  = 32'(signed'(coef.mc_md[31:16]));
	assign md  = 32'(signed'(coef.mc_md[15:0]));

	logic signed [31:0] t_raw, mcs, den, b3s, x3s, psh, pr;
	logic [31:0] x1sum, b6_next, b4m, p_mag;
	logic [31:0] mul_a, mul_b, mul_p;
	logic [15:0] sat;
	assign den  = signed'(x1_q) + md;
	assign mcs  = mc <<< 11;
	// signed division by magnitude; sign fixed afterward
	assign x1sum = signed'(x1_q) + signed'(x2_q);
	assign b6_next = x1sum - 32'd4000;
	assign t_raw = (signed'(b5_q) + 32'sd8) >>> 4;
	assign sat = (t_raw > 32'sd32767) ? 16'h7fff :
		(t_raw < -32'sd32768) ? 16'h8000 : t_raw[15:0];
	assign b3s = (((ac1 <<< 2) + signed'(x1_q) + signed'(x2_q)) <<< coef.oss) + 32'sd2;
	assign x3s = (signed'(x1_q) + signed'(x2_q) + 32'sd2) >>> 2;
	assign b4m = x3s + 32'd32768;
	assign p_mag = b7hi_q ? {div_quo[30:0], 1'b0} : div_quo;
	assign psh = signed'(p_mag) >>> 8;
	assign pr = ((signed'(x1_q) + signed'(x2_q) + 32'sd3791) >>> 4) + signed'(p_q);

	// single shared multiplier, low 32 bits only
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (st_q)
			S_X1T: begin
				mul_a = 32'(ut_q) - 32'(ac6);
				mul_b = 32'(ac5);
			end
			S_SQ: begin
				mul_a = b6_next;
				mul_b = b6_next;
			end
			S_X1B2: begin
				mul_a = sq_q;
				mul_b = b2;
			end
			S_AC2: begin
				mul_a = ac2;
				mul_b = b6_q;
			end
			S_AC3: begin
				mul_a = ac3;
				mul_b = b6_q;
			end
			S_B1: begin
				mul_a = sq_q;
				mul_b = b1;
			end
			S_B4: begin
				mul_a = b4m;
				mul_b = 32'(ac4);
			end
			S_B7: begin
				mul_a = 32'(up_q) - b3_q;
				mul_b = 32'd50000 >> coef.oss;
			end
			S_P1: begin
				mul_a = psh;
				mul_b = psh;
			end
			S_P2: begin
				mul_a = x1_q;
				mul_b = 32'd3038;
			end
			S_P3: begin
				mul_a = -32'sd7357;
				mul_b = p_q;
			end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	bpc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_quo)
	);

	// divider operands per phase
	always_comb begin
		div_start = 1'b0;
		div_a = '0;
		div_b = '0;
		if (st_q == S_SDIV) begin
			div_start = 1'b1;
			div_a = mcs[31] ? 32'(-mcs) : mcs;
			div_b = x2_q[31] ? 32'(-signed'(x2_q)) : x2_q;
		end else if (st_q == S_PDIV) begin
			div_start = 1'b1;
			div_a = b7hi_q ? b7_q : {b7_q[30:0], 1'b0};
			div_b = b4_q;
		end
	end

	assign q_pop = (st_q == S_IDLE) && q_valid;
	assign res_valid = out_full_q;
	assign out_load = (st_q == S_OUT) && (!out_full_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_full_q <= 1'b0;
		end else begin
			if (out_load)
				out_full_q <= 1'b1;
			else if (res_ready)
				out_full_q <= 1'b0;
			unique case (st_q)
				S_IDLE:  if (q_valid) st_q <= S_X1T;
				S_X1T:   st_q <= S_DEN;
				S_DEN:   st_q <= (den == '0) ? S_OUT : S_SDIV;
				S_SDIV:  st_q <= S_WDIV;
				S_WDIV:  if (div_done) st_q <= S_B5;
				S_B5:    st_q <= S_SQ;
				S_SQ:    st_q <= S_X1B2;
				S_X1B2:  st_q <= S_AC2;
				S_AC2:   st_q <= S_B3;
				S_B3:    st_q <= S_AC3;
				S_AC3:   st_q <= S_B1;
				S_B1:    st_q <= S_B4;
				S_B4:    st_q <= S_B4C;
				S_B4C:   st_q <= (b4_q == '0) ? S_OUT : S_B7;
				S_B7:    st_q <= S_PDIV;
				S_PDIV:  st_q <= S_PW;
				S_PW:    if (div_done) st_q <= S_P1;
				S_P1:    st_q <= S_P2;
				S_P2:    st_q <= S_P3;
				S_P3:    st_q <= S_P4;
				S_P4:    st_q <= S_OUT;
				S_OUT:   if (out_load) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				ut_q <= q_item.raw_temp;
				up_q <= q_item.raw_press;
				// zero results with error unless the item completes
				re_q <= 1'b1;
				rt_q <= '0;
				rp_q <= '0;
			end
			S_X1T: x1_q <= signed'(mul_p) >>> 15;
			S_DEN: begin
				x2_q  <= den;
				neg_q <= mcs[31] ^ den[31];
			end
			S_B5: x2_q <= neg_q ? 32'(-signed'(div_quo)) : div_quo;
			S_SQ: begin
				b5_q <= x1sum;
				b6_q <= b6_next;
				sq_q <= signed'(mul_p) >>> 12;
			end
			S_X1B2: x1_q <= signed'(mul_p) >>> 11;
			S_AC2:  x2_q <= signed'(mul_p) >>> 11;
			S_B3:   b3_q <= b3s / 32'sd4;
			S_AC3:  x1_q <= signed'(mul_p) >>> 13;
			S_B1:   x2_q <= signed'(mul_p) >>> 16;
			S_B4:   b4_q <= {15'd0, mul_p[31:15]};
			S_B7: begin
				b7_q <= mul_p;
				b7hi_q <= mul_p[31];
			end
			S_P1: begin
				p_q <= p_mag;
				x1_q <= mul_p;
			end
			S_P2: x1_q <= signed'(mul_p) >>> 16;
			S_P3: x2_q <= signed'(mul_p) >>> 16;
			S_P4: begin
				re_q <= 1'b0;
				rt_q <= sat;
				rp_q <= pr;
			end
			S_OUT: if (out_load) res <= {rt_q, rp_q, re_q};
			default: ;
		endcase
	end

	ap_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == S_WDIV || st_q == S_PW)) else $error("stray done");
	ap_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> st_q == S_X1T) else $error("pop without start");
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid) else $error("result dropped");
	ap_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> $stable(res)) else $error("result changed");

endmodule

// File: rtl/core/barometric_pressure_compensation_top.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top
// Integer temperature and pressure compensation with stream ports.
// ----------------------------------------------------------------------------
// An item occupies the sequencer through two waits on the shared 32-step
// divider (temperature and pressure divisions) and 20 further steps with at
// most one multiply each. The sequencer takes one item at a time: it pops the
// next item only after the last result is loaded into the result register. A
// two-entry input queue and the result register let both sides stall
// independently. Coefficients are written through the cfg port; the user must
// write them only while the block is idle, as the block does not enforce it.
module barometric_pressure_compensation_top import bpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // raw_temp[15:0], raw_press[39:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // temp_deci_c[15:0], press_pa[47:16]
	output logic        m_tuser,  // div_error
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_wdata
);

	bpc_coef_t   coef_q;
	bpc_item_t   in_item, q_item;
	bpc_result_t res;
	logic        q_valid, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_AC1_AC2: coef_q.ac1_ac2 <= cfg_wdata;
				REG_AC3_AC4: coef_q.ac3_ac4 <= cfg_wdata;
				REG_AC5_AC6: coef_q.ac5_ac6 <= cfg_wdata;
				REG_B1_B2:   coef_q.b1_b2 <= cfg_wdata;
				REG_MC_MD:   coef_q.mc_md <= cfg_wdata;
				REG_OSS:     coef_q.oss <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	assign in_item.raw_temp  = s_tdata[15:0];
	assign in_item.raw_press = s_tdata[39:16];

	bpc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
	);

	bpc_back u_back (
		.clk(clk), .arst_n(arst_n), .coef(coef_q), .q_valid(q_valid), .q_pop(q_pop),
		.q_item(q_item), .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
	);

	assign m_tdata = {res.press_pa, res.temp_deci_c};
	assign m_tuser = res.div_error;

endmodule
